// ----- rtl/baro_temp_compensation_core_defines.svh -----
// Assertion macros for the baro temperature compensation core.
// Used by baro_temp_compensation_core.sv; expects clock and reset in scope.
`ifndef BARO_TEMP_COMPENSATION_CORE_DEFINES_SVH
`define BARO_TEMP_COMPENSATION_CORE_DEFINES_SVH

// implication checked outside reset
`define BTC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, also checked through reset
`define BTC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/btc_pkg.sv -----
// Package for the baro temperature compensation core: widths, register
// indexes and the side-band word carried through the divider. No dependencies.
`default_nettype none

package btc_pkg;

   localparam int RAW_W      = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_W      = 64;
   localparam int DIV_W      = 80;
   localparam int Q_W        = 56;
   localparam int DIV_STAGES = Q_W / 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CAL_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CAL_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CAL_C = 2'd3;

   typedef struct packed {
      logic signed [15:0] temp_c;
      logic signed [15:0] temp_f;
      logic               neg;
      logic               inv;
   } side_type;

endpackage

`default_nettype wire

// ----- rtl/btc_div.sv -----
// Pipelined restoring divider, two quotient bits per stage, saturating at 2^Q_W.
// Depends on btc_pkg.
`default_nettype none

module btc_div import btc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_vld,
   input  wire logic [DIV_W-1:0] in_x,
   input  wire logic [DIV_W-1:0] in_d,
   input  wire side_type         in_side,
   output logic                  out_vld,
   output logic [Q_W:0]          out_q,
   output side_type              out_side
);

   logic             vld_ff  [0:DIV_STAGES];
   logic             sat_ff  [0:DIV_STAGES];
   logic [DIV_W-1:0] rem_ff  [0:DIV_STAGES];
   logic [DIV_W-1:0] den_ff  [0:DIV_STAGES];
   logic [Q_W-1:0]   quo_ff  [0:DIV_STAGES];
   side_type         side_ff [0:DIV_STAGES];
   logic             sat_in;

   assign sat_in = (in_x >= in_d);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      sat_ff[0]  <= sat_in;
      rem_ff[0]  <= sat_in ? '0 : in_x;
      den_ff[0]  <= in_d;
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_W:0]   t0, t1;
      logic [DIV_W-1:0] r1, rem_in;
      logic             b0, b1;

      always_comb begin
         t0     = {rem_ff[k], 1'b0};
         b1     = (t0 >= {1'b0, den_ff[k]});
         r1     = b1 ? DIV_W'(t0 - {1'b0, den_ff[k]}) : t0[DIV_W-1:0];
         t1     = {r1, 1'b0};
         b0     = (t1 >= {1'b0, den_ff[k]});
         rem_in = b0 ? DIV_W'(t1 - {1'b0, den_ff[k]}) : t1[DIV_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         sat_ff[k+1]  <= sat_ff[k];
         rem_ff[k+1]  <= rem_in;
         den_ff[k+1]  <= den_ff[k];
         quo_ff[k+1]  <= {quo_ff[k][Q_W-3:0], b1, b0};
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES];
   assign out_q    = sat_ff[DIV_STAGES] ? {1'b1, Q_W'(0)} : {1'b0, quo_ff[DIV_STAGES]};
   assign out_side = side_ff[DIV_STAGES];

endmodule

`default_nettype wire

// ----- rtl/baro_temp_compensation_core.sv -----
// Top level of the baro temperature compensation core.
// Depends on btc_pkg, btc_div and baro_temp_compensation_core_defines.svh.
`default_nettype none
`include "baro_temp_compensation_core_defines.svh"

// Usage:
// A conversion word (req_raw_temp, req_raw_press) is taken at each rising edge
// with start high and busy low. busy is low except during reset, so a new word
// may enter every cycle: throughput one word per clock.
// Each result word appears on the rsp_ ports for one cycle with rsp_strobe
// high, in order. The pipeline is made of the pressure divider (an input
// stage and 28 stages of two quotient bits each), nine stages of polynomial
// evaluation ahead of it and six stages of correction after it.
// The receiver cannot stall; the pipeline never holds.
// Calibration is written through csr_we/csr_index/csr_wdata, one register per
// cycle; the user must do so only while no word is in flight (not enforced).
// Reset clears the calibration registers and empties the pipeline; words in
// flight are dropped.
// A zero pressure divisor gives rsp_press_q8_pa 0 and rsp_press_valid low.

module baro_temp_compensation_core import btc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [RAW_W-1:0]     req_raw_temp,
   input  wire logic [RAW_W-1:0]     req_raw_press,
   output logic                      rsp_strobe,
   output logic signed [15:0]        rsp_temp_centi_c,
   output logic signed [15:0]        rsp_temp_centi_f,
   output logic [31:0]               rsp_press_q8_pa,
   output logic                      rsp_press_valid,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int LATENCY = 9 + DIV_STAGES + 1 + 6;

   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -24'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // calibration
   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff, press_cal_b_ff;
   logic [15:0] press_cal_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         press_cal_c_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_CAL:    temp_cal_ff    <= csr_wdata[47:0];
            CSR_PRESS_CAL_A: press_cal_a_ff <= csr_wdata;
            CSR_PRESS_CAL_B: press_cal_b_ff <= csr_wdata;
            CSR_PRESS_CAL_C: press_cal_c_ff <= csr_wdata[15:0];
         endcase
      end
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_cal_ff[15:0];
   assign t2 = temp_cal_ff[31:16];
   assign t3 = temp_cal_ff[47:32];
   assign p1 = press_cal_a_ff[15:0];
   assign p2 = press_cal_a_ff[31:16];
   assign p3 = press_cal_a_ff[47:32];
   assign p4 = press_cal_a_ff[63:48];
   assign p5 = press_cal_b_ff[15:0];
   assign p6 = press_cal_b_ff[31:16];
   assign p7 = press_cal_b_ff[47:32];
   assign p8 = press_cal_b_ff[63:48];
   assign p9 = press_cal_c_ff;

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // valid chain ahead of the divider
   logic [9:1] v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[8:1], accept};
      end
   end

   // stage 1
   logic signed [21:0] d1_ff, d1_in;
   logic [RAW_W-1:0]   rp1_ff;
   assign d1_in = $signed({2'b00, req_raw_temp}) - $signed({2'b00, t1, 4'b0000});

   // stage 2
   logic signed [37:0] a2_ff, a2_in;
   logic signed [43:0] dd2_ff, dd2_in;
   logic [RAW_W-1:0]   rp2_ff;
   assign a2_in  = 38'(d1_ff) * 38'(t2);
   assign dd2_in = 44'(d1_ff) * 44'(d1_ff);

   // stage 3
   logic signed [58:0] s3_ff, s3_in;
   logic [RAW_W-1:0]   rp3_ff;
   assign s3_in = (59'(a2_ff) <<< 20) + 59'(dd2_ff) * 59'(t3);

   // stage 4: t_fine, h, temperature magnitudes
   logic signed [58:0] tsum;
   logic signed [24:0] tfine;
   logic signed [23:0] h4_ff, h4_in;
   logic signed [61:0] s5x, s9x;
   logic [61:0]        mag5_ff, mag5_in, mag9_ff, mag9_in;
   logic               sn4_ff;
   logic [RAW_W-1:0]   rp4_ff;
   always_comb begin
      tsum    = s3_ff + (s3_ff[58] ? 59'(34'h3_FFFF_FFFF) : 59'sd0);
      tfine   = tsum[58:34];
      h4_in   = 24'(tfine) - 24'sd128000;
      s5x     = (62'(s3_ff) <<< 2) + 62'(s3_ff);
      s9x     = (62'(s3_ff) <<< 3) + 62'(s3_ff);
      mag5_in = s5x[61] ? 62'(-s5x) : 62'(s5x);
      mag9_in = s9x[61] ? 62'(-s9x) : 62'(s9x);
   end

   // stage 5: temperature words, h products
   logic [61:0]        rnd5, rnd9;
   logic signed [23:0] c5v, f5v;
   logic signed [15:0] tc5_ff, tc5_in, tf5_ff, tf5_in;
   logic signed [47:0] hh5_ff, hh5_in;
   logic signed [39:0] hp5_ff, hp5_in, hp2_ff, hp2_in;
   logic [RAW_W-1:0]   rp5_ff;
   always_comb begin
      rnd5   = (mag5_ff + (62'd1 << 41)) >> 42;
      rnd9   = (mag9_ff + (62'd1 << 41)) >> 42;
      c5v    = sn4_ff ? -$signed({3'b000, rnd5[20:0]}) : $signed({3'b000, rnd5[20:0]});
      f5v    = (sn4_ff ? -$signed({3'b000, rnd9[20:0]}) : $signed({3'b000, rnd9[20:0]}))
               + 24'sd3200;
      tc5_in = sat16(c5v);
      tf5_in = sat16(f5v);
      hh5_in = 48'(h4_ff) * 48'(h4_ff);
      hp5_in = 40'(h4_ff) * 40'(p5);
      hp2_in = 40'(h4_ff) * 40'(p2);
   end

   // stage 6: N2 and M
   logic signed [63:0] n2_6_ff, n2_6_in, m6_ff, m6_in;
   logic [RAW_W-1:0]   rp6_ff;
   logic signed [15:0] tc6_ff, tf6_ff;
   assign n2_6_in = 64'(hh5_ff) * 64'(p6) + (64'(hp5_ff) <<< 17) + (64'(p4) <<< 35);
   assign m6_in   = (64'sd1 <<< 55) + 64'(p3) * 64'(hh5_ff) + (64'(hp2_ff) <<< 20);

   // stage 7: numerator
   logic signed [21:0] dp7;
   logic signed [63:0] num7_ff, num7_in, m7_ff;
   logic signed [15:0] tc7_ff, tf7_ff;
   assign dp7     = 22'sd1048576 - $signed({2'b00, rp6_ff});
   assign num7_in = (64'(dp7) <<< 31) - n2_6_ff;

   // stage 8: magnitudes
   logic [63:0]        na8_ff, na8_in, ma8_ff, ma8_in;
   logic               neg8_ff, inv8_ff;
   logic signed [15:0] tc8_ff, tf8_ff;
   assign na8_in = num7_ff[63] ? 64'(-num7_ff) : 64'(num7_ff);
   assign ma8_in = m7_ff[63] ? 64'(-m7_ff) : 64'(m7_ff);

   // stage 9: dividend and divisor
   logic [DIV_W-1:0] x9_ff, x9_in, d9_ff, d9_in;
   side_type         side9_ff;
   assign x9_in = DIV_W'(na8_ff) * DIV_W'(13'd6250);
   assign d9_in = DIV_W'(p1) * DIV_W'(ma8_ff);

   always_ff @(posedge clock) begin
      d1_ff   <= d1_in;
      rp1_ff  <= req_raw_press;
      a2_ff   <= a2_in;
      dd2_ff  <= dd2_in;
      rp2_ff  <= rp1_ff;
      s3_ff   <= s3_in;
      rp3_ff  <= rp2_ff;
      h4_ff   <= h4_in;
      mag5_ff <= mag5_in;
      mag9_ff <= mag9_in;
      sn4_ff  <= s3_ff[58];
      rp4_ff  <= rp3_ff;
      tc5_ff  <= tc5_in;
      tf5_ff  <= tf5_in;
      hh5_ff  <= hh5_in;
      hp5_ff  <= hp5_in;
      hp2_ff  <= hp2_in;
      rp5_ff  <= rp4_ff;
      n2_6_ff <= n2_6_in;
      m6_ff   <= m6_in;
      rp6_ff  <= rp5_ff;
      tc6_ff  <= tc5_ff;
      tf6_ff  <= tf5_ff;
      num7_ff <= num7_in;
      m7_ff   <= m6_ff;
      tc7_ff  <= tc6_ff;
      tf7_ff  <= tf6_ff;
      na8_ff  <= na8_in;
      ma8_ff  <= ma8_in;
      neg8_ff <= num7_ff[63] ^ m7_ff[63];
      inv8_ff <= (p1 == 16'd0) || (m7_ff == 64'sd0);
      tc8_ff  <= tc7_ff;
      tf8_ff  <= tf7_ff;
      x9_ff   <= x9_in;
      d9_ff   <= d9_in;
      side9_ff.temp_c <= tc8_ff;
      side9_ff.temp_f <= tf8_ff;
      side9_ff.neg    <= neg8_ff;
      side9_ff.inv    <= inv8_ff;
   end

   // divider
   logic     div_vld;
   logic [Q_W:0] div_q;
   side_type div_side;

   btc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v_ff[9]),
      .in_x     (x9_ff),
      .in_d     (d9_ff),
      .in_side  (side9_ff),
      .out_vld  (div_vld),
      .out_q    (div_q),
      .out_side (div_side)
   );

   // correction: P1 squares and P8 product
   logic [Q_W:0]       q1_ff;
   logic [55:0]        sqa_ff, sqa_in;
   logic [56:0]        sqb_ff, sqb_in;
   logic [57:0]        sqc_ff, sqc_in;
   logic signed [73:0] pr8_ff, pr8_in;
   side_type           sd1_ff;
   assign sqa_in = 56'(div_q[56:29]) * 56'(div_q[56:29]);
   assign sqb_in = 57'(div_q[56:29]) * 57'(div_q[28:0]);
   assign sqc_in = 58'(div_q[28:0]) * 58'(div_q[28:0]);
   assign pr8_in = 74'(p8) * 74'($signed({1'b0, div_q}));

   // P2: q^2, signed p, P8 term
   logic [113:0]       sq2_ff, sq2_in;
   logic signed [73:0] sp8;
   logic signed [63:0] t8_2_ff, t8_2_in, ps2_ff, ps2_in;
   side_type           sd2_ff;
   always_comb begin
      sq2_in  = (114'(sqa_ff) << 58) + (114'(sqb_ff) << 30) + 114'(sqc_ff);
      sp8     = sd1_ff.neg ? -pr8_ff : pr8_ff;
      t8_2_in = 64'(sp8 >>> 19);
      ps2_in  = sd1_ff.neg ? -$signed(64'(q1_ff)) : $signed(64'(q1_ff));
   end

   // P3: P9 partial products
   logic [115:0]       sqp;
   logic signed [45:0] pp3_ff [0:3];
   logic signed [45:0] pp3_in [0:3];
   logic signed [63:0] t8_3_ff, ps3_ff;
   side_type           sd3_ff;
   assign sqp = {2'b00, sq2_ff};
   for (genvar k = 0; k < 4; k++) begin : g_pp
      assign pp3_in[k] = 46'(p9) * 46'($signed({1'b0, sqp[29*k +: 29]}));
   end

   // P4: P9 term
   logic signed [131:0] pr4;
   logic signed [63:0]  t9_4_ff, t9_4_in, t8_4_ff, ps4_ff;
   side_type            sd4_ff;
   always_comb begin
      pr4 = 132'(pp3_ff[0]) + (132'(pp3_ff[1]) <<< 29) + (132'(pp3_ff[2]) <<< 58)
            + (132'(pp3_ff[3]) <<< 87);
      t9_4_in = 64'(pr4 >>> 67);
   end

   // P5: corrected pressure in Q32
   logic signed [63:0] f5_ff, f5_in;
   side_type           sd5_ff;
   assign f5_in = ps4_ff + t9_4_ff + t8_4_ff + (64'(p7) <<< 28);

   // P6: rounding to Q24.8 into the output word
   logic [63:0] rnd6;
   logic [31:0] press_in;
   always_comb begin
      rnd6 = (64'(f5_ff) + (64'd1 << 23)) >> 24;
      if (sd5_ff.inv || f5_ff <= 64'sd0) begin
         press_in = '0;
      end else if (rnd6[63:32] != 32'd0) begin
         press_in = '1;
      end else begin
         press_in = rnd6[31:0];
      end
   end

   logic [6:1] pv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= {pv_ff[5:1], div_vld};
      end
   end

   logic               rsp_pv_ff;
   logic signed [15:0] rsp_tc_ff, rsp_tf_ff;
   logic [31:0]        rsp_press_ff;
   logic               rsp_valid_ff;

   always_ff @(posedge clock) begin
      q1_ff   <= div_q;
      sqa_ff  <= sqa_in;
      sqb_ff  <= sqb_in;
      sqc_ff  <= sqc_in;
      pr8_ff  <= pr8_in;
      sd1_ff  <= div_side;
      sq2_ff  <= sq2_in;
      t8_2_ff <= t8_2_in;
      ps2_ff  <= ps2_in;
      sd2_ff  <= sd1_ff;
      for (int k = 0; k < 4; k++) begin
         pp3_ff[k] <= pp3_in[k];
      end
      t8_3_ff <= t8_2_ff;
      ps3_ff  <= ps2_ff;
      sd3_ff  <= sd2_ff;
      t9_4_ff <= t9_4_in;
      t8_4_ff <= t8_3_ff;
      ps4_ff  <= ps3_ff;
      sd4_ff  <= sd3_ff;
      f5_ff   <= f5_in;
      sd5_ff  <= sd4_ff;
      rsp_tc_ff    <= sd5_ff.temp_c;
      rsp_tf_ff    <= sd5_ff.temp_f;
      rsp_press_ff <= press_in;
      rsp_valid_ff <= !sd5_ff.inv;
   end

   assign rsp_pv_ff        = pv_ff[6];
   assign rsp_strobe       = rsp_pv_ff;
   assign rsp_temp_centi_c = rsp_tc_ff;
   assign rsp_temp_centi_f = rsp_tf_ff;
   assign rsp_press_q8_pa  = rsp_press_ff;
   assign rsp_press_valid  = rsp_valid_ff;

   `BTC_ASSERT_IMP(a_strobe_follows_word, rsp_strobe, $past(start && !busy, LATENCY),
                   "result word without a matching request word")
   `BTC_ASSERT_IMP(a_invalid_zero, rsp_strobe && !rsp_press_valid, rsp_press_q8_pa == 32'd0,
                   "invalid pressure word is not zero")
   `BTC_ASSERT_NXT(a_reset_quiet, reset, !rsp_strobe,
                   "result strobe right after reset")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for baro_temp_compensation_core: compensates random and
// corner-case conversion words across several calibration sets. Depends on btc_pkg.
`timescale 1ns / 1ps

module tb import btc_pkg::*; ();

   typedef logic signed [255:0] wide_type;
   localparam wide_type ONE = 1;

   typedef struct {
      logic signed [15:0] temp_c;
      logic signed [15:0] temp_f;
      logic [31:0]        press;
      logic               valid;
   } comp_word_type;

   class comp_scoreboard;
      logic [63:0]   cal [4];
      comp_word_type pending [$];
      int            mismatches;

      function void set_cal(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
         case (idx)
            CSR_TEMP_CAL:    cal[idx] = {16'd0, val[47:0]};
            CSR_PRESS_CAL_C: cal[idx] = {48'd0, val[15:0]};
            default:         cal[idx] = val;
         endcase
      endfunction

      function wide_type sx(logic [15:0] v);
         return wide_type'($signed(v));
      endfunction

      function wide_type half_away(wide_type v, int n);
         wide_type a;
         a = v < 0 ? -v : v;
         a = (a + (ONE <<< (n - 1))) >>> n;
         return v < 0 ? -a : a;
      endfunction

      function logic [15:0] clip16(wide_type v);
         if (v > 32767) return 16'h7FFF;
         if (v < -32768) return 16'h8000;
         return v[15:0];
      endfunction

      function void note(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
         wide_type t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         wide_type d, s, tf, h, n2, m, num, x, dv, q, ps, t9, t8, f, pr;
         comp_word_type w;
         t1 = $signed({240'd0, cal[0][15:0]});
         t2 = sx(cal[0][31:16]);
         t3 = sx(cal[0][47:32]);
         p1 = $signed({240'd0, cal[1][15:0]});
         p2 = sx(cal[1][31:16]);
         p3 = sx(cal[1][47:32]);
         p4 = sx(cal[1][63:48]);
         p5 = sx(cal[2][15:0]);
         p6 = sx(cal[2][31:16]);
         p7 = sx(cal[2][47:32]);
         p8 = sx(cal[2][63:48]);
         p9 = sx(cal[3][15:0]);
         d  = $signed({236'd0, rt}) - 16 * t1;
         s  = d * t2 * 1048576 + d * d * t3;
         tf = s / (ONE <<< 34);
         h  = tf - 128000;
         n2 = h * h * p6 + h * p5 * 131072 + p4 * (ONE <<< 35);
         m  = (ONE <<< 55) + p3 * h * h + p2 * h * 1048576;
         num = (1048576 - $signed({236'd0, rp})) * (ONE <<< 31) - n2;
         w.temp_c = clip16(half_away(5 * s, 42));
         w.temp_f = clip16(half_away(9 * s, 42) + 3200);
         w.press  = '0;
         w.valid  = 1'b0;
         if (p1 != 0 && m != 0) begin
            x  = ((num < 0 ? -num : num) * 6250) <<< 56;
            dv = p1 * (m < 0 ? -m : m);
            q  = x / dv;
            if (q > (ONE <<< 56)) q = ONE <<< 56;
            ps = ((num < 0) != (m < 0)) ? -q : q;
            t9 = (p9 * q * q) >>> 67;
            t8 = (p8 * ps) >>> 19;
            f  = ps + t9 + t8 + p7 * (ONE <<< 28);
            if (f > 0) begin
               pr = (f + (ONE <<< 23)) >>> 24;
               if (pr > (ONE <<< 32) - 1) pr = (ONE <<< 32) - 1;
               w.press = pr[31:0];
            end
            w.valid = 1'b1;
         end
         pending.push_back(w);
      endfunction

      function void check(comp_word_type got);
         comp_word_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            return;
         end
         e = pending.pop_front();
         if (got.temp_c !== e.temp_c || got.temp_f !== e.temp_f ||
             got.press !== e.press || got.valid !== e.valid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: exp c=%0d f=%0d p=%h v=%b  got c=%0d f=%0d p=%h v=%b",
                        $realtime, e.temp_c, e.temp_f, e.press, e.valid,
                        got.temp_c, got.temp_f, got.press, got.valid);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [RAW_W-1:0]     req_raw_temp;
   logic [RAW_W-1:0]     req_raw_press;
   logic                 rsp_strobe;
   logic signed [15:0]   rsp_temp_centi_c;
   logic signed [15:0]   rsp_temp_centi_f;
   logic [31:0]          rsp_press_q8_pa;
   logic                 rsp_press_valid;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   comp_scoreboard sb = new();
   bit burst;

   baro_temp_compensation_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_temp(req_raw_temp), .req_raw_press(req_raw_press),
      .rsp_strobe(rsp_strobe), .rsp_temp_centi_c(rsp_temp_centi_c),
      .rsp_temp_centi_f(rsp_temp_centi_f), .rsp_press_q8_pa(rsp_press_q8_pa),
      .rsp_press_valid(rsp_press_valid), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      comp_word_type got;
      if (!reset && rsp_strobe) begin
         got.temp_c = rsp_temp_centi_c;
         got.temp_f = rsp_temp_centi_f;
         got.press  = rsp_press_q8_pa;
         got.valid  = rsp_press_valid;
         sb.check(got);
      end
   end

   // csr_we stays high across back-to-back writes; load_cal drops it
   task automatic write_cal(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_cal(idx, val);
   endtask

   task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                           logic [15:0] pc);
      write_cal(CSR_TEMP_CAL, {16'd0, tc});
      write_cal(CSR_PRESS_CAL_A, pa);
      write_cal(CSR_PRESS_CAL_B, pb);
      write_cal(CSR_PRESS_CAL_C, {48'd0, pc});
      csr_we <= 1'b0;
   endtask

   // start stays high across back-to-back words
   task automatic send_word(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_raw_temp  <= rt;
      req_raw_press <= rp;
      do @(posedge clock); while (busy);
      sb.note(rt, rp);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [RAW_W-1:0] rt, rp;
      int n;
      start         <= 1'b0;
      req_raw_temp  <= '0;
      req_raw_press <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_TEMP_CAL;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: ; // reset calibration: zero divisor
            1: load_cal({16'hFC18, 16'd26435, 16'd27504},
                        {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                        {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
            2: load_cal('1, '1, '1, '1);
            3: load_cal({16'h7FFF, 16'h7FFF, 16'h0000},
                        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h8000);
            4: load_cal({16'h8000, 16'h8000, 16'hFFFF},
                        {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                        {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h7FFF);
            5: load_cal({16'hFC18, 16'd26435, 16'd27504},
                        {16'd2855, 16'd3024, 16'hD643, 16'd1},
                        {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
            6, 7: load_cal({16'($urandom_range(0, 200)) - 16'd100 + 16'hFC18,
                            16'd26435 + 16'($urandom_range(0, 511)),
                            16'd27504 + 16'($urandom_range(0, 511))},
                           {16'd2855 + 16'($urandom_range(0, 255)), 16'd3024,
                            16'hD643 + 16'($urandom_range(0, 255)),
                            16'd36477 - 16'($urandom_range(0, 4095))},
                           {$urandom, $urandom} & 64'h0000_7FFF_000F_00FF,
                           16'($urandom_range(0, 8191)));
            default: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                              {$urandom, $urandom}, 16'($urandom));
         endcase
         burst = 1'b0;
         if (ph < 5) begin
            send_word('0, '0);
            send_word('1, '1);
            send_word('0, '1);
            send_word('1, '0);
            send_word(20'd519888, 20'd415148);
         end
         n = (ph < 5) ? 150 : 160;
         for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 1)) begin
               rt = 20'($urandom);
               rp = 20'($urandom);
            end else begin
               rt = 20'd519888 + 20'($urandom_range(0, 32767)) - 20'd16384;
               rp = 20'd415148 + 20'($urandom_range(0, 131071)) - 20'd65536;
            end
            send_word(rt, rp);
         end
         drain();
      end
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
